// ----- src/ptd_pkg.sv -----
// Shared widths, types, region codes and helpers for the point-triangle distance core.
package ptd_pkg;

   // Field and number formats
   localparam int FieldWidth  = 32;
   localparam int CoordWidth  = 32;
   localparam int FracBits    = 16;
   localparam int DistWidth   = 64;
   localparam int RegionWidth = 3;

   // Derived datapath widths
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int ProdWidth  = 2 * DiffWidth;
   localparam int DotWidth   = ProdWidth + 2;
   localparam int HalfWidth  = DotWidth / 2;
   localparam int PartWidth  = 2 * HalfWidth + 2;
   localparam int WideWidth  = 2 * DotWidth;
   localparam int ParamWidth = FracBits + 1;
   localparam int DfWidth    = DiffWidth + FracBits + 2;
   localparam int MagWidth   = DfWidth - 1;
   localparam int SqLoWidth  = MagWidth / 2;
   localparam int SqHiWidth  = MagWidth - SqLoWidth;
   localparam int SqWidth    = 2 * MagWidth;
   localparam int SumWidth   = SqWidth + 2;
   localparam int AccWidth   = (SumWidth > 2 * FracBits + DistWidth + 1) ?
                               SumWidth : 2 * FracBits + DistWidth + 1;
   localparam int GeoWidth   = 9 * DiffWidth;

   // Pipeline depth: seven front stages, divider, seven back stages
   localparam int DivLatency = FracBits + 1;
   localparam int Latency    = FracBits + 15;

   typedef logic signed [DiffWidth-1:0]   diff_type;
   typedef logic signed [ProdWidth-1:0]   prod_type;
   typedef logic signed [DotWidth-1:0]    dot_type;
   typedef logic signed [HalfWidth-1:0]   half_type;
   typedef logic signed [HalfWidth:0]     lowext_type;
   typedef logic signed [PartWidth-1:0]   part_type;
   typedef logic signed [WideWidth-1:0]   wide_type;
   typedef logic        [ParamWidth-1:0]  param_type;
   typedef logic signed [DfWidth-1:0]     df_type;
   typedef logic        [MagWidth-1:0]    mag_type;
   typedef logic        [2*SqHiWidth-1:0] sqp_type;
   typedef logic        [SqWidth-1:0]     sq_type;
   typedef logic        [AccWidth-1:0]    acc_type;
   typedef logic        [DistWidth-1:0]   dist_type;
   typedef logic        [RegionWidth-1:0] region_type;

   localparam param_type ParamOne = param_type'(1) << FracBits;

   // Region codes of the seven-region test
   localparam region_type Region0 = 3'd0;
   localparam region_type Region1 = 3'd1;
   localparam region_type Region2 = 3'd2;
   localparam region_type Region3 = 3'd3;
   localparam region_type Region4 = 3'd4;
   localparam region_type Region5 = 3'd5;
   localparam region_type Region6 = 3'd6;

   // Per-item control that rides along the divider
   typedef struct packed {
      region_type region;
      logic       degenerate;
      logic       t_from_s;
   } meta_type;

   // Difference of two coordinates read in their low CoordWidth bits
   function automatic diff_type coord_diff(input logic [FieldWidth-1:0] p,
                                           input logic [FieldWidth-1:0] q);
      return diff_type'($signed(p[CoordWidth-1:0])) - diff_type'($signed(q[CoordWidth-1:0]));
   endfunction

endpackage

// ----- src/point_triangle_distance_core.sv -----
// Top level: pipelined squared distance from a point to a triangle, fixed point.
//
//   channel   ports                         handshake
//   request   req_vert_*, req_query_*       beat taken when start & !busy
//   response  rsp_dist_squared, rsp_region, one-cycle beat marked by rsp_valid
//             rsp_degenerate
//
// A new beat may enter on every clock; busy is high only during reset.
// Each beat passes through seven front stages, the FracBits + 1 stage divider
// and seven back stages.
// Reset is synchronous and clears only the valid chain; no beat in flight survives it.
// The receiver cannot stall, so the pipeline never holds.
module point_triangle_distance_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_vert_a_x,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_vert_a_y,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_vert_a_z,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_vert_b_x,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_vert_b_y,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_vert_b_z,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_vert_c_x,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_vert_c_y,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_vert_c_z,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_query_x,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_query_y,
   input  logic [ptd_pkg::FieldWidth-1:0]   req_query_z,
   output logic                             rsp_valid,
   output logic [ptd_pkg::DistWidth-1:0]    rsp_dist_squared,
   output logic [ptd_pkg::RegionWidth-1:0]  rsp_region,
   output logic                             rsp_degenerate
);

   localparam int DW        = ptd_pkg::DiffWidth;
   localparam int GW        = ptd_pkg::GeoWidth;
   localparam int WMsb      = ptd_pkg::WideWidth - 1;
   localparam int Latency   = ptd_pkg::Latency;
   localparam int GeoDepth  = ptd_pkg::FracBits + 9;
   localparam int MetaDepth = ptd_pkg::FracBits + 8;
   localparam int MetaTap   = ptd_pkg::DivLatency;

   // Vector slots in the geometry word
   localparam int VecE0 = 0;
   localparam int VecE1 = 1;
   localparam int VecV0 = 2;
   // Dot product slots
   localparam int DotA = 0;
   localparam int DotB = 1;
   localparam int DotC = 2;
   localparam int DotD = 3;
   localparam int DotE = 4;
   localparam int DotLeft  [5] = '{VecE0, VecE0, VecE1, VecE0, VecE1};
   localparam int DotRight [5] = '{VecE0, VecE1, VecE1, VecV0, VecV0};
   // Wide product slots: ac, bb, be, cd, bd, ae
   localparam int WideAC = 0;
   localparam int WideBB = 1;
   localparam int WideBE = 2;
   localparam int WideCD = 3;
   localparam int WideBD = 4;
   localparam int WideAE = 5;
   localparam int WideLeft  [6] = '{DotA, DotB, DotB, DotC, DotB, DotA};
   localparam int WideRight [6] = '{DotC, DotB, DotE, DotD, DotD, DotE};
   // Partial product slots
   localparam int PartHH = 0;
   localparam int PartHL = 1;
   localparam int PartLH = 2;
   localparam int PartLL = 3;

   function automatic ptd_pkg::diff_type geo_elem(input logic [GW-1:0] g,
                                                  input int v, input int k);
      return ptd_pkg::diff_type'(g[(v*3+k)*DW +: DW]);
   endfunction

   logic                accept;
   logic [Latency-1:0]  valid_ff;
   logic [GW-1:0]       geo_in;
   logic [GW-1:0]       geo_ff [GeoDepth];

   ptd_pkg::prod_type   prod_in [5][3];
   ptd_pkg::prod_type   prod_ff [5][3];
   ptd_pkg::dot_type    dot_in  [5];
   ptd_pkg::dot_type    dot_ff  [5];
   ptd_pkg::dot_type    dot4_ff [5];
   ptd_pkg::dot_type    dot5_ff [5];
   ptd_pkg::part_type   part_in [6][4];
   ptd_pkg::part_type   part_ff [6][4];
   ptd_pkg::wide_type   wide_in [6];
   ptd_pkg::wide_type   wide_ff [6];

   ptd_pkg::wide_type   det_in, sn_in, tn_in, numer_in, denom_in, a_in, c_in, nd_in, ne_in;
   logic                lt_bdce_in, lt_bead_in, dneg_in, zero_ac_in;
   ptd_pkg::wide_type   det_ff, sn_ff, tn_ff, numer_ff, denom_ff, a_ff, c_ff, nd_ff, ne_ff;
   logic                lt_bdce_ff, lt_bead_ff, dneg_ff, zero_ac_ff;

   ptd_pkg::wide_type   num_s_in, den_s_in, num_t_in, den_t_in;
   ptd_pkg::wide_type   num_s_ff, den_s_ff, num_t_ff, den_t_ff;
   ptd_pkg::meta_type   meta_in;
   ptd_pkg::meta_type   meta_ff [MetaDepth];
   logic                in_tri;

   ptd_pkg::param_type  quot_s, quot_t;
   ptd_pkg::param_type  tp_in;
   ptd_pkg::param_type  sp_ff, tp_ff;
   ptd_pkg::df_type     ps_ff [3];
   ptd_pkg::df_type     pt_ff [3];
   ptd_pkg::df_type     vs_ff [3];
   ptd_pkg::df_type     df_ff [3];
   ptd_pkg::mag_type    mag_ff [3];
   ptd_pkg::sqp_type    sqhh_ff [3];
   ptd_pkg::sqp_type    sqhl_ff [3];
   ptd_pkg::sqp_type    sqll_ff [3];
   ptd_pkg::sq_type     sq_ff [3];

   ptd_pkg::acc_type    acc_in, shifted_in;
   logic                sat_in;
   ptd_pkg::dist_type   rsp_dist_ff;
   ptd_pkg::region_type rsp_region_ff;
   logic                rsp_degenerate_ff;

   // Handshake
   assign busy   = reset;
   assign accept = start & ~busy;

   // Advance the valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[Latency-2:0], accept};
      end
   end

   // Stage 1: edge vectors E0, E1 and offset V0
   assign geo_in = {ptd_pkg::coord_diff(req_vert_a_z, req_query_z),
                    ptd_pkg::coord_diff(req_vert_a_y, req_query_y),
                    ptd_pkg::coord_diff(req_vert_a_x, req_query_x),
                    ptd_pkg::coord_diff(req_vert_c_z, req_vert_a_z),
                    ptd_pkg::coord_diff(req_vert_c_y, req_vert_a_y),
                    ptd_pkg::coord_diff(req_vert_c_x, req_vert_a_x),
                    ptd_pkg::coord_diff(req_vert_b_z, req_vert_a_z),
                    ptd_pkg::coord_diff(req_vert_b_y, req_vert_a_y),
                    ptd_pkg::coord_diff(req_vert_b_x, req_vert_a_x)};

   // Carry the geometry down to the distance stages
   always_ff @(posedge clock) begin
      geo_ff[0] <= geo_in;
      for (int i = 1; i < GeoDepth; i++) begin
         geo_ff[i] <= geo_ff[i-1];
      end
   end

   // Stage 2: component products of the five dot products
   always_comb begin
      for (int j = 0; j < 5; j++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[j][k] = ptd_pkg::prod_type'(geo_elem(geo_ff[0], DotLeft[j], k))
                          * ptd_pkg::prod_type'(geo_elem(geo_ff[0], DotRight[j], k));
         end
      end
   end

   // Stage 3: sum components into a, b, c, d, e
   always_comb begin
      for (int j = 0; j < 5; j++) begin
         dot_in[j] = ptd_pkg::dot_type'(prod_ff[j][0]) + ptd_pkg::dot_type'(prod_ff[j][1])
                   + ptd_pkg::dot_type'(prod_ff[j][2]);
      end
   end

   // Stage 4: split each wide product into four partial products
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         ptd_pkg::half_type   hx, hy;
         ptd_pkg::lowext_type lx, ly;
         hx = ptd_pkg::half_type'(dot_ff[WideLeft[j]][ptd_pkg::DotWidth-1:ptd_pkg::HalfWidth]);
         hy = ptd_pkg::half_type'(dot_ff[WideRight[j]][ptd_pkg::DotWidth-1:ptd_pkg::HalfWidth]);
         lx = ptd_pkg::lowext_type'({1'b0, dot_ff[WideLeft[j]][ptd_pkg::HalfWidth-1:0]});
         ly = ptd_pkg::lowext_type'({1'b0, dot_ff[WideRight[j]][ptd_pkg::HalfWidth-1:0]});
         part_in[j][PartHH] = ptd_pkg::part_type'(hx) * ptd_pkg::part_type'(hy);
         part_in[j][PartHL] = ptd_pkg::part_type'(hx) * ptd_pkg::part_type'(ly);
         part_in[j][PartLH] = ptd_pkg::part_type'(lx) * ptd_pkg::part_type'(hy);
         part_in[j][PartLL] = ptd_pkg::part_type'(lx) * ptd_pkg::part_type'(ly);
      end
   end

   // Stage 5: recombine partial products
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         wide_in[j] = (ptd_pkg::wide_type'(part_ff[j][PartHH]) <<< (2 * ptd_pkg::HalfWidth))
                    + ((ptd_pkg::wide_type'(part_ff[j][PartHL])
                      + ptd_pkg::wide_type'(part_ff[j][PartLH])) <<< ptd_pkg::HalfWidth)
                    + ptd_pkg::wide_type'(part_ff[j][PartLL]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      dot_ff  <= dot_in;
      dot4_ff <= dot_ff;
      dot5_ff <= dot4_ff;
      part_ff <= part_in;
      wide_ff <= wide_in;
   end

   // Stage 6: det, sn, tn, edge-two terms and side compares
   always_comb begin
      ptd_pkg::wide_type wa, wb, wc, wd, we;
      wa = ptd_pkg::wide_type'(dot5_ff[DotA]);
      wb = ptd_pkg::wide_type'(dot5_ff[DotB]);
      wc = ptd_pkg::wide_type'(dot5_ff[DotC]);
      wd = ptd_pkg::wide_type'(dot5_ff[DotD]);
      we = ptd_pkg::wide_type'(dot5_ff[DotE]);
      det_in     = wide_ff[WideAC] - wide_ff[WideBB];
      sn_in      = wide_ff[WideBE] - wide_ff[WideCD];
      tn_in      = wide_ff[WideBD] - wide_ff[WideAE];
      numer_in   = (wc + we) - (wb + wd);
      denom_in   = (wa + wc) - (wb + wb);
      a_in       = wa;
      c_in       = wc;
      nd_in      = ptd_pkg::wide_type'(0) - wd;
      ne_in      = ptd_pkg::wide_type'(0) - we;
      lt_bdce_in = (wb + wd) < (wc + we);
      lt_bead_in = (wb + we) < (wa + wd);
      dneg_in    = dot5_ff[DotD][ptd_pkg::DotWidth-1];
      zero_ac_in = (dot5_ff[DotA] == '0) | (dot5_ff[DotC] == '0);
   end

   always_ff @(posedge clock) begin
      det_ff     <= det_in;
      sn_ff      <= sn_in;
      tn_ff      <= tn_in;
      numer_ff   <= numer_in;
      denom_ff   <= denom_in;
      a_ff       <= a_in;
      c_ff       <= c_in;
      nd_ff      <= nd_in;
      ne_ff      <= ne_in;
      lt_bdce_ff <= lt_bdce_in;
      lt_bead_ff <= lt_bead_in;
      dneg_ff    <= dneg_in;
      zero_ac_ff <= zero_ac_in;
   end

   // Stage 7: region test and choice of divider operands (idle divider gets 0/1)
   assign in_tri = (sn_ff + tn_ff) < det_ff;

   always_comb begin
      num_s_in           = '0;
      den_s_in           = ptd_pkg::wide_type'(1);
      num_t_in           = '0;
      den_t_in           = ptd_pkg::wide_type'(1);
      meta_in.region     = ptd_pkg::Region0;
      meta_in.degenerate = zero_ac_ff | (det_ff == '0);
      meta_in.t_from_s   = 1'b0;
      if (meta_in.degenerate) begin
         meta_in.region = ptd_pkg::Region0;
      end else if (in_tri) begin
         if (sn_ff[WMsb]) begin
            if (tn_ff[WMsb]) begin
               meta_in.region = ptd_pkg::Region4;
               if (dneg_ff) begin
                  num_s_in = nd_ff;
                  den_s_in = a_ff;
               end else begin
                  num_t_in = ne_ff;
                  den_t_in = c_ff;
               end
            end else begin
               meta_in.region = ptd_pkg::Region3;
               num_t_in = ne_ff;
               den_t_in = c_ff;
            end
         end else if (tn_ff[WMsb]) begin
            meta_in.region = ptd_pkg::Region5;
            num_s_in = nd_ff;
            den_s_in = a_ff;
         end else begin
            meta_in.region = ptd_pkg::Region0;
            num_s_in = sn_ff;
            den_s_in = det_ff;
            num_t_in = tn_ff;
            den_t_in = det_ff;
         end
      end else begin
         if (sn_ff[WMsb]) begin
            meta_in.region = ptd_pkg::Region2;
            if (lt_bdce_ff) begin
               num_s_in = numer_ff;
               den_s_in = denom_ff;
               meta_in.t_from_s = 1'b1;
            end else begin
               num_t_in = ne_ff;
               den_t_in = c_ff;
            end
         end else if (tn_ff[WMsb]) begin
            meta_in.region = ptd_pkg::Region6;
            if (lt_bead_ff) begin
               num_s_in = numer_ff;
               den_s_in = denom_ff;
               meta_in.t_from_s = 1'b1;
            end else begin
               num_s_in = nd_ff;
               den_s_in = a_ff;
            end
         end else begin
            meta_in.region = ptd_pkg::Region1;
            num_s_in = numer_ff;
            den_s_in = denom_ff;
            meta_in.t_from_s = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_s_ff   <= num_s_in;
      den_s_ff   <= den_s_in;
      num_t_ff   <= num_t_in;
      den_t_ff   <= den_t_in;
      meta_ff[0] <= meta_in;
      for (int i = 1; i < MetaDepth; i++) begin
         meta_ff[i] <= meta_ff[i-1];
      end
   end

   // Divide for s and t
   ptd_divider u_div_s (
      .clock (clock),
      .num   (num_s_ff),
      .den   (den_s_ff),
      .quot  (quot_s)
   );

   ptd_divider u_div_t (
      .clock (clock),
      .num   (num_t_ff),
      .den   (den_t_ff),
      .quot  (quot_t)
   );

   // Back stage 1: final s and t
   assign tp_in = meta_ff[MetaTap].t_from_s ? (ptd_pkg::ParamOne - quot_s) : quot_t;

   always_ff @(posedge clock) begin
      sp_ff <= quot_s;
      tp_ff <= tp_in;
   end

   // Back stages 2 to 6: difference vector, magnitude, split squares
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ps_ff[k]   <= ptd_pkg::df_type'($signed({1'b0, sp_ff}))
                     * ptd_pkg::df_type'(geo_elem(geo_ff[GeoDepth-1], VecE0, k));
         pt_ff[k]   <= ptd_pkg::df_type'($signed({1'b0, tp_ff}))
                     * ptd_pkg::df_type'(geo_elem(geo_ff[GeoDepth-1], VecE1, k));
         vs_ff[k]   <= ptd_pkg::df_type'(geo_elem(geo_ff[GeoDepth-1], VecV0, k))
                     <<< ptd_pkg::FracBits;
         df_ff[k]   <= vs_ff[k] + ps_ff[k] + pt_ff[k];
         mag_ff[k]  <= df_ff[k][ptd_pkg::DfWidth-1] ? ptd_pkg::mag_type'(-df_ff[k])
                                                     : ptd_pkg::mag_type'(df_ff[k]);
         sqhh_ff[k] <= ptd_pkg::sqp_type'(mag_ff[k][ptd_pkg::MagWidth-1:ptd_pkg::SqLoWidth])
                     * ptd_pkg::sqp_type'(mag_ff[k][ptd_pkg::MagWidth-1:ptd_pkg::SqLoWidth]);
         sqhl_ff[k] <= ptd_pkg::sqp_type'(mag_ff[k][ptd_pkg::MagWidth-1:ptd_pkg::SqLoWidth])
                     * ptd_pkg::sqp_type'(mag_ff[k][ptd_pkg::SqLoWidth-1:0]);
         sqll_ff[k] <= ptd_pkg::sqp_type'(mag_ff[k][ptd_pkg::SqLoWidth-1:0])
                     * ptd_pkg::sqp_type'(mag_ff[k][ptd_pkg::SqLoWidth-1:0]);
         sq_ff[k]   <= (ptd_pkg::sq_type'(sqhh_ff[k]) << (2 * ptd_pkg::SqLoWidth))
                     + (ptd_pkg::sq_type'(sqhl_ff[k]) << (ptd_pkg::SqLoWidth + 1))
                     + ptd_pkg::sq_type'(sqll_ff[k]);
      end
   end

   // Back stage 7: sum, drop fraction bits, saturate
   assign acc_in     = ptd_pkg::acc_type'(sq_ff[0]) + ptd_pkg::acc_type'(sq_ff[1])
                     + ptd_pkg::acc_type'(sq_ff[2]);
   assign shifted_in = acc_in >> (2 * ptd_pkg::FracBits);
   assign sat_in     = |shifted_in[ptd_pkg::AccWidth-1:ptd_pkg::DistWidth];

   always_ff @(posedge clock) begin
      rsp_dist_ff       <= sat_in ? '1 : shifted_in[ptd_pkg::DistWidth-1:0];
      rsp_region_ff     <= meta_ff[MetaDepth-1].region;
      rsp_degenerate_ff <= meta_ff[MetaDepth-1].degenerate;
   end

   assign rsp_valid        = valid_ff[Latency-1];
   assign rsp_dist_squared = rsp_dist_ff;
   assign rsp_region       = rsp_region_ff;
   assign rsp_degenerate   = rsp_degenerate_ff;

   // Every taken beat comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(ptd_pkg::Latency) rsp_valid)
      else $error("response beat missing after fixed latency");

   // No response beat without a request beat
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, ptd_pkg::Latency))
      else $error("response beat without matching request beat");

   // Degenerate triangles report region zero
   a_degen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_region == ptd_pkg::Region0))
      else $error("degenerate beat with nonzero region");

endmodule

// ----- src/ptd_divider.sv -----
// Pipelined clamped quotient unit: num/den clamped to 0..1, one quotient bit per stage.
module ptd_divider (
   input  logic               clock,
   input  ptd_pkg::wide_type  num,
   input  ptd_pkg::wide_type  den,
   output ptd_pkg::param_type quot
);

   localparam int Steps = ptd_pkg::FracBits;
   localparam int Msb   = ptd_pkg::WideWidth - 1;

   ptd_pkg::wide_type rem_ff  [Steps+1];
   ptd_pkg::wide_type den_ff  [Steps+1];
   logic [Steps-1:0]  q_ff    [Steps+1];
   logic              zero_ff [Steps+1];
   logic              one_ff  [Steps+1];

   logic zero_in;
   logic one_in;

   // Classify the quotient before the bit loop
   assign zero_in = num[Msb] | (num == '0);
   assign one_in  = !(num < den);

   always_ff @(posedge clock) begin
      rem_ff[0]  <= num;
      den_ff[0]  <= den;
      q_ff[0]    <= '0;
      zero_ff[0] <= zero_in;
      one_ff[0]  <= one_in;
   end

   // One restoring step per stage
   for (genvar k = 0; k < Steps; k++) begin : g_step
      ptd_pkg::wide_type shift_rem;
      logic              take;
      ptd_pkg::wide_type rem_in;
      logic [Steps-1:0]  q_in;

      assign shift_rem = rem_ff[k] <<< 1;
      assign take      = !(shift_rem < den_ff[k]);
      assign rem_in    = take ? (shift_rem - den_ff[k]) : shift_rem;
      assign q_in      = {q_ff[k][Steps-2:0], take};

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= rem_in;
         den_ff[k+1]  <= den_ff[k];
         q_ff[k+1]    <= q_in;
         zero_ff[k+1] <= zero_ff[k];
         one_ff[k+1]  <= one_ff[k];
      end
   end

   // Apply the clamp
   assign quot = zero_ff[Steps] ? '0 :
                 one_ff[Steps]  ? ptd_pkg::ParamOne : {1'b0, q_ff[Steps]};

endmodule
